[hdl/bba_pkg.sv]
package bba_pkg;

  localparam int MAP_BITS   = 1024;
  localparam int INDEX_SPAN = 1024;
  localparam int IDX_W      = 10;
  localparam int REG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int WORD_W  = 32;
  localparam int WORD_AW = $clog2(WORD_W);
  localparam int ROWS    = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TROW_W  = REG_W - WORD_AW;
  localparam int CMP_W   = (ROW_AW > TROW_W) ? ROW_AW : TROW_W;
  localparam int SCAN_W  = $clog2(INDEX_SPAN / WORD_W + 1);
  localparam int LIM_MAX = (MAP_BITS < INDEX_SPAN) ? MAP_BITS : INDEX_SPAN;

  typedef enum logic [1:0] {
    CMD_FORMAT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2
  } bba_cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_FREE_RANGE = 2'd2
  } bba_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL = 2'd0,
    CFG_FLOOR = 2'd1
  } bba_cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR
  } bba_state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] block_index;
  } bba_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic [1:0]       status;
  } bba_rsp_t;

  // bits of a row whose global index lies below top
  function automatic logic [WORD_W-1:0] row_mask(input logic [CMP_W-1:0] row,
                                                 input logic [REG_W-1:0] top);
    logic [CMP_W-1:0]  trow;
    logic [WORD_W-1:0] m;
    trow = CMP_W'(top[REG_W-1:WORD_AW]);
    if (row < trow) begin
      m = '1;
    end else if (row == trow) begin
      m = (WORD_W'(1) << top[WORD_AW-1:0]) - WORD_W'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // position of the lowest set bit
  function automatic logic [WORD_AW-1:0] find_low(input logic [WORD_W-1:0] f);
    logic [WORD_W-1:0]  iso;
    logic [WORD_AW-1:0] pos;
    iso = f & (~f + WORD_W'(1));
    pos = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (iso[j]) begin
        pos = pos | WORD_AW'(j);
      end
    end
    return pos;
  endfunction

endpackage

[hdl/bba_ram.sv]
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bitmap_block_allocator_core.sv]
// format: one map row written per cycle, then the result
// allocate: one 32-bit row per cycle, answered straight from idle with no usable block
// free: read-modify-write of one row, answered straight from idle when out of range
// one request at a time; busy stays high until the result strobe, results cannot stall
// reset: asynchronous active low, then a clearing pass over all map rows with busy high
module bitmap_block_allocator_core
  import bba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bba_req_t             req_i,
  output logic                 done_o,
  output bba_rsp_t             rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  bba_state_e state_q, state_d;

  logic [REG_W-1:0]  total_q, floor_q;
  logic [ROW_AW-1:0] sweep_row_q;
  logic [REG_W-1:0]  sweep_top_q;
  logic              sweep_rsp_q;
  logic [SCAN_W-1:0] scan_row_q, chk_row_q;
  logic              rd_pend_q;
  logic [IDX_W-1:0]  blk_q;
  logic              done_q, done_d;
  bba_rsp_t          rsp_q, rsp_d;

  logic              accept;
  logic [REG_W-1:0]  lim, fmt_top;
  logic [SCAN_W-1:0] nrows;
  logic              free_ok, sweep_last, chk_last;
  logic [WORD_W-1:0] free_bits;
  logic              hit;
  logic [WORD_AW-1:0] hit_pos;
  logic [REG_W-1:0]  hit_idx;
  logic [ROW_AW-1:0] blk_row;

  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    lim = total_q;
    if (32'(total_q) > LIM_MAX) begin
      lim = REG_W'(LIM_MAX);
    end
    fmt_top = floor_q;
    if (32'(floor_q) > MAP_BITS) begin
      fmt_top = REG_W'(MAP_BITS);
    end
  end

  assign nrows      = SCAN_W'((lim + REG_W'(WORD_W - 1)) >> WORD_AW);
  assign free_ok    = ({1'b0, req_i.block_index} >= floor_q) &&
                      ({1'b0, req_i.block_index} < lim);
  assign sweep_last = (sweep_row_q == ROW_AW'(ROWS - 1));
  assign chk_last   = (chk_row_q == nrows - SCAN_W'(1));
  assign free_bits  = ~ram_rdata & row_mask(CMP_W'(chk_row_q), lim);
  assign hit        = |free_bits;
  assign hit_pos    = find_low(free_bits);
  assign hit_idx    = REG_W'({chk_row_q, hit_pos});
  assign blk_row    = ROW_AW'(blk_q[IDX_W-1:WORD_AW]);

  bba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            CMD_FORMAT: state_d = S_SWEEP;
            CMD_ALLOC:  state_d = (lim == '0) ? S_IDLE : S_SCAN;
            CMD_FREE:   state_d = free_ok ? S_FREE_RD : S_IDLE;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        if (sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_pend_q && (hit || chk_last)) begin
          state_d = S_IDLE;
        end
      end
      S_FREE_RD: state_d = S_FREE_WR;
      S_FREE_WR: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs and map access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_row_q;
    ram_wdata = row_mask(CMP_W'(sweep_row_q), sweep_top_q);
    ram_re    = 1'b0;
    ram_raddr = ROW_AW'(scan_row_q);
    done_d    = 1'b0;
    rsp_d     = '{granted_index: '0, status: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            CMD_FORMAT: ;
            CMD_ALLOC: begin
              if (lim == '0) begin
                done_d       = 1'b1;
                rsp_d.status = ST_ALLOC_FAIL;
              end
            end
            CMD_FREE: begin
              if (!free_ok) begin
                done_d       = 1'b1;
                rsp_d.status = ST_FREE_RANGE;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_SWEEP: begin
        ram_we = 1'b1;
        done_d = sweep_last && sweep_rsp_q;
      end
      S_SCAN: begin
        ram_re = (scan_row_q < nrows);
        if (rd_pend_q) begin
          if (hit) begin
            done_d = 1'b1;
            if (hit_idx < floor_q) begin
              rsp_d.status = ST_ALLOC_FAIL;
            end else begin
              ram_we              = 1'b1;
              ram_waddr           = ROW_AW'(chk_row_q);
              ram_wdata           = ram_rdata | (WORD_W'(1) << hit_pos);
              rsp_d.granted_index = hit_idx[IDX_W-1:0];
            end
          end else if (chk_last) begin
            done_d       = 1'b1;
            rsp_d.status = ST_ALLOC_FAIL;
          end
        end
      end
      S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = blk_row;
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = blk_row;
        ram_wdata = ram_rdata & ~(WORD_W'(1) << blk_q[WORD_AW-1:0]);
        done_d    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      total_q     <= REG_W'(1024);
      floor_q     <= REG_W'(5);
      sweep_row_q <= '0;
      sweep_top_q <= '0;
      sweep_rsp_q <= 1'b0;
      scan_row_q  <= '0;
      chk_row_q   <= '0;
      rd_pend_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TOTAL: total_q <= cfg_data_i;
          CFG_FLOOR: floor_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            sweep_row_q <= '0;
            sweep_top_q <= fmt_top;
            sweep_rsp_q <= 1'b1;
            scan_row_q  <= '0;
            rd_pend_q   <= 1'b0;
          end
        end
        S_SWEEP: sweep_row_q <= sweep_row_q + ROW_AW'(1);
        S_SCAN: begin
          if (ram_re) begin
            scan_row_q <= scan_row_q + SCAN_W'(1);
          end
          rd_pend_q <= ram_re;
          chk_row_q <= scan_row_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      blk_q <= req_i.block_index;
    end
  end

endmodule

[hdl/bba_checker.sv]
module bba_checker
  import bba_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input bba_req_t req_i,
  input logic     done_o,
  input bba_rsp_t rsp_o
);

  // a result only follows an accepted request or a busy period
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a request");

  // the block is free again when the result shows
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy while result strobe is high");

  // an accepted request either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request dropped");

  // a granted index only comes with an ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.granted_index != '0)) |-> (rsp_o.status == ST_OK))
    else $error("granted index with error status");

  // unknown command answers at once with ok and no grant
  a_unknown_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd != CMD_FORMAT) && (req_i.cmd != CMD_ALLOC) &&
     (req_i.cmd != CMD_FREE)) |=>
      (done_o && (rsp_o.status == ST_OK) && (rsp_o.granted_index == '0)))
    else $error("unknown command mishandled");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);

[tb/tb_bitmap_block_allocator_core.sv]
module tb_bitmap_block_allocator_core;
  import bba_pkg::*;

  localparam int          CLK_PERIOD     = 12;
  localparam longint      TIMEOUT_CYCLES = 600000;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int          SEGMENTS       = 6;
  localparam int          SEG_ITEMS      = 95;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  bba_req_t             req_i;
  logic                 done_o;
  bba_rsp_t             rsp_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [REG_W-1:0]     cfg_data_i;

  bit               used_bits [MAP_BITS];
  logic [REG_W-1:0] total_reg;
  logic [REG_W-1:0] floor_reg;
  bba_rsp_t         pending_rsp_q [$];
  bba_rsp_t         due_rsp;
  int unsigned      fail_count;
  int unsigned      idle_pct;

  bitmap_block_allocator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int usable_limit();
    if (total_reg > LIM_MAX) begin
      return LIM_MAX;
    end
    return int'(total_reg);
  endfunction

  // applies one request to the map copy and returns the expected answer
  function automatic bba_rsp_t map_apply(bba_req_t r);
    int       lim;
    int       top;
    int       i;
    bit       found;
    bba_rsp_t e;
    lim = usable_limit();
    e.granted_index = '0;
    e.status = ST_OK;
    case (r.cmd)
      CMD_FORMAT: begin
        top = (floor_reg > MAP_BITS) ? MAP_BITS : int'(floor_reg);
        for (i = 0; i < MAP_BITS; i++) begin
          used_bits[i] = (i < top);
        end
      end
      CMD_ALLOC: begin
        i = 0;
        found = 1'b0;
        while (i < lim && !found) begin
          if (!used_bits[i]) begin
            found = 1'b1;
          end else begin
            i++;
          end
        end
        if (!found || i < floor_reg) begin
          e.status = ST_ALLOC_FAIL;
        end else begin
          used_bits[i] = 1'b1;
          e.granted_index = IDX_W'(i);
        end
      end
      CMD_FREE: begin
        if (r.block_index < floor_reg || r.block_index >= lim) begin
          e.status = ST_FREE_RANGE;
        end else begin
          used_bits[r.block_index] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual granted_index %0d status %0d",
                 $time, rsp_o.granted_index, rsp_o.status);
        fail_count++;
      end else begin
        due_rsp = pending_rsp_q.pop_front();
        if (rsp_o.granted_index !== due_rsp.granted_index) begin
          $display("%0t granted_index mismatch: expected %0d actual %0d",
                   $time, due_rsp.granted_index, rsp_o.granted_index);
          fail_count++;
        end
        if (rsp_o.status !== due_rsp.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, due_rsp.status, rsp_o.status);
          fail_count++;
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge with start still high
  task automatic send_req(input logic [1:0] cmd, input logic [IDX_W-1:0] blk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    req_i.cmd = cmd;
    req_i.block_index = blk;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    pending_rsp_q.push_back(map_apply(req_i));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_rsp_q.size() != 0 || busy) begin
      @(negedge clk_i);
    end
  endtask

  task automatic cfg_write(input bba_cfg_e idx, input int unsigned val);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = REG_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TOTAL) begin
      total_reg = REG_W'(val);
    end else begin
      floor_reg = REG_W'(val);
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // map left as cleared by reset, floor at its reset value
  task automatic test_reset_state();
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 10'd4);
    send_req(CMD_FREE, 10'd1023);
    send_req(CMD_UNUSED, 10'd1023);
  endtask

  task automatic test_format_alloc_free();
    send_req(CMD_FORMAT, '0);
    send_req(CMD_ALLOC, 10'd1023);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 10'd6);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 10'd100);
  endtask

  task automatic test_total_limits();
    cfg_write(CFG_TOTAL, 7);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 10'd7);
    cfg_write(CFG_TOTAL, 0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 10'd5);
    cfg_write(CFG_TOTAL, 2047);
    cfg_write(CFG_FLOOR, 1023);
    send_req(CMD_FORMAT, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_ALLOC, '0);
  endtask

  task automatic test_floor_cases();
    cfg_write(CFG_TOTAL, 1024);
    cfg_write(CFG_FLOOR, 2047);
    send_req(CMD_FORMAT, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 10'd1023);
    cfg_write(CFG_FLOOR, 0);
    cfg_write(CFG_TOTAL, 1);
    send_req(CMD_FORMAT, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, 10'd1);
    // floor raised over a free block without a format
    send_req(CMD_FREE, 10'd0);
    cfg_write(CFG_FLOOR, 8);
    send_req(CMD_ALLOC, '0);
  endtask

  task automatic test_random_traffic(input int segs, input int items);
    int          s;
    int          n;
    int          lim;
    int unsigned pick;
    int unsigned tot;
    int unsigned flr;
    int unsigned blk;
    for (s = 0; s < segs; s++) begin
      case ($urandom_range(0, 9))
        0: begin
          tot = 0;
          flr = $urandom_range(0, 8);
        end
        1: begin
          tot = 1024;
          flr = 1024 - $urandom_range(1, 48);
        end
        2: begin
          tot = 2047;
          flr = $urandom_range(980, 1030);
        end
        3: begin
          tot = $urandom_range(1, 40);
          flr = tot + $urandom_range(0, 3);
        end
        4: begin
          tot = 1024;
          flr = 1024;
        end
        default: begin
          tot = $urandom_range(1, 96);
          flr = $urandom_range(0, tot / 2);
        end
      endcase
      if ($urandom_range(1)) begin
        cfg_write(CFG_TOTAL, tot);
        cfg_write(CFG_FLOOR, flr);
      end else begin
        cfg_write(CFG_FLOOR, flr);
        cfg_write(CFG_TOTAL, tot);
      end
      if ($urandom_range(99) < 80) begin
        send_req(CMD_FORMAT, IDX_W'($urandom_range(0, 1023)));
      end
      lim = usable_limit();
      for (n = 0; n < items; n++) begin
        pick = $urandom_range(99);
        blk = $urandom_range(0, 1023);
        if (pick < 50) begin
          send_req(CMD_ALLOC, IDX_W'(blk));
        end else if (pick < 88) begin
          if ($urandom_range(99) < 75 && lim > floor_reg) begin
            blk = $urandom_range(int'(floor_reg), lim - 1);
          end
          send_req(CMD_FREE, IDX_W'(blk));
        end else if (pick < 94) begin
          send_req(CMD_FORMAT, IDX_W'(blk));
        end else begin
          send_req(CMD_UNUSED, IDX_W'(blk));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_TOTAL;
    cfg_data_i = '0;
    fail_count = 0;
    idle_pct = 0;
    total_reg = REG_W'(1024);
    floor_reg = REG_W'(5);
    for (int i = 0; i < MAP_BITS; i++) begin
      used_bits[i] = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 19;
    test_reset_state();
    test_format_alloc_free();
    test_total_limits();
    test_floor_cases();
    test_random_traffic(SEGMENTS, SEG_ITEMS);
    idle_pct = 79;
    test_random_traffic(SEGMENTS, SEG_ITEMS);
    idle_pct = 0;
    test_random_traffic(SEGMENTS, SEG_ITEMS);

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bitmap_block_allocator_core regression: pass");
    end else begin
      $display("bitmap_block_allocator_core regression: fail");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("bitmap_block_allocator_core regression: fail");
    $finish;
  end

endmodule

[sim.f]
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bitmap_block_allocator_core.sv
hdl/bba_checker.sv
tb/tb_bitmap_block_allocator_core.sv
